### src/ptfc_pkg.sv
// shared constants and types of the point triangle feature classifier
`default_nettype none
package ptfc_pkg;

	localparam int TOL_W = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;
	localparam int TSQ_W = 2 * (TOL_W + 1);
	localparam int CHUNK_W = 34;

	localparam int NEXT_IDX [3] = '{1, 2, 0};
	localparam int XD_IDX [6] = '{1, 2, 2, 0, 0, 1};
	localparam int XP_IDX [6] = '{2, 1, 0, 2, 1, 0};

	typedef enum logic [1:0] {
		FEAT_VERTEX = 2'd0,
		FEAT_EDGE   = 2'd1,
		FEAT_FACE   = 2'd2
	} feature_t;

endpackage
`default_nettype wire

### src/ptfc_mul.sv
// pipelined signed multiplier built from narrow partial products
`default_nettype none
module ptfc_mul #(
	parameter int A_W = 33,
	parameter int B_W = 33
) (
	input  logic                        clk,
	input  logic signed [A_W-1:0]       a,
	input  logic signed [B_W-1:0]       b,
	output logic signed [A_W+B_W-1:0]   p
);
	import ptfc_pkg::*;

	localparam int NA = (A_W + CHUNK_W - 1) / CHUNK_W;
	localparam int NB = (B_W + CHUNK_W - 1) / CHUNK_W;
	localparam int AX_W = NA * CHUNK_W;
	localparam int BX_W = NB * CHUNK_W;
	localparam int P_W = A_W + B_W;
	localparam int PP_W = 2 * CHUNK_W + 2;

	logic signed [AX_W-1:0] a_x;
	logic signed [BX_W-1:0] b_x;
	logic signed [CHUNK_W:0] a_c [NA];
	logic signed [CHUNK_W:0] b_c [NB];
	logic signed [PP_W-1:0] pp_s1 [NA][NB];
	logic signed [P_W-1:0] acc;
	logic signed [P_W-1:0] prod_s2;

	assign a_x = AX_W'(a);
	assign b_x = BX_W'(b);

	// lower chunks unsigned, top chunk carries the sign
	for (genvar i = 0; i < NA; i++) begin : g_a
		if (i == NA - 1) begin : g_top
			assign a_c[i] = $signed({a_x[AX_W-1], a_x[i*CHUNK_W +: CHUNK_W]});
		end else begin : g_low
			assign a_c[i] = $signed({1'b0, a_x[i*CHUNK_W +: CHUNK_W]});
		end
	end
	for (genvar j = 0; j < NB; j++) begin : g_b
		if (j == NB - 1) begin : g_top
			assign b_c[j] = $signed({b_x[BX_W-1], b_x[j*CHUNK_W +: CHUNK_W]});
		end else begin : g_low
			assign b_c[j] = $signed({1'b0, b_x[j*CHUNK_W +: CHUNK_W]});
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				pp_s1[i][j] <= a_c[i] * b_c[j];
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + (P_W'(pp_s1[i][j]) <<< (CHUNK_W * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= acc;
	end

	assign p = prod_s2;

endmodule
`default_nettype wire

### src/ptfc_edge.sv
// distance test of the query point against the line through one edge
`default_nettype none
module ptfc_edge #(
	parameter int DW = 33
) (
	input  logic                              clk,
	input  logic signed [DW-1:0]              d_s1 [3],
	input  logic signed [DW-1:0]              p_s1 [3],
	input  logic signed [ptfc_pkg::TSQ_W-1:0] tol_sq_s3,
	output logic                              near_s8
);
	import ptfc_pkg::*;

	localparam int PW = 2 * DW;
	localparam int CW = PW + 1;
	localparam int LW = PW + 2;
	localparam int QW = 2 * CW;
	localparam int SW = QW + 2;
	localparam int TW = LW + TSQ_W;

	logic signed [PW-1:0] xm [6];
	logic signed [PW-1:0] dsq [3];
	logic signed [CW-1:0] c_s4 [3];
	logic signed [LW-1:0] len_s4;
	logic signed [TSQ_W-1:0] tsq_s4;
	logic signed [QW-1:0] csq [3];
	logic signed [TW-1:0] tl;
	logic lnz_s5, lnz_s6, lnz_s7;
	logic signed [SW-1:0] xsq_s7;
	logic signed [TW-1:0] tl_s7;

	// cross product terms
	for (genvar m = 0; m < 6; m++) begin : g_x
		ptfc_mul #(.A_W(DW), .B_W(DW)) u_xm (
			.clk (clk),
			.a   (d_s1[XD_IDX[m]]),
			.b   (p_s1[XP_IDX[m]]),
			.p   (xm[m])
		);
	end

	// squared edge length terms
	for (genvar k = 0; k < 3; k++) begin : g_d
		ptfc_mul #(.A_W(DW), .B_W(DW)) u_dsq (
			.clk (clk),
			.a   (d_s1[k]),
			.b   (d_s1[k]),
			.p   (dsq[k])
		);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			c_s4[k] <= CW'(xm[2*k]) - CW'(xm[2*k+1]);
		end
		len_s4 <= LW'(dsq[0]) + LW'(dsq[1]) + LW'(dsq[2]);
		tsq_s4 <= tol_sq_s3;
	end

	for (genvar k = 0; k < 3; k++) begin : g_c
		ptfc_mul #(.A_W(CW), .B_W(CW)) u_csq (
			.clk (clk),
			.a   (c_s4[k]),
			.b   (c_s4[k]),
			.p   (csq[k])
		);
	end

	ptfc_mul #(.A_W(LW), .B_W(TSQ_W)) u_tl (
		.clk (clk),
		.a   (len_s4),
		.b   (tsq_s4),
		.p   (tl)
	);

	always_ff @(posedge clk) begin
		lnz_s5 <= (len_s4 != '0);
		lnz_s6 <= lnz_s5;
		lnz_s7 <= lnz_s6;
		xsq_s7 <= SW'(csq[0]) + SW'(csq[1]) + SW'(csq[2]);
		tl_s7 <= tl;
		near_s8 <= lnz_s7 && (xsq_s7 < SW'(tl_s7));
	end

endmodule
`default_nettype wire

### src/point_triangle_feature_classify.sv
// top level of the point triangle feature classifier
//
// classifies a query point against a triangle, all coordinates signed q16.16
// start with the twelve coordinate ports issues an item; it is taken at any
// rising edge with start high and busy low, and busy stays low, so one item
// can be issued in every cycle
// the result appears on feature with done high for exactly one cycle, once
// the item has passed the pipeline registers s1 to s9; items come out in
// issue order
// throughput is one item per cycle, set by the multiplier pipelines: a
// partial product stage and a summing stage per multiply, two multiply layers
// (cross products, then their squares) with adder and compare stages between
// the tolerance register is written through cfg_valid / cfg_ready / cfg_data;
// cfg_ready is always high, and a write should only happen with no item in
// flight
// reset clears the valid pipeline so no result is shown, and loads the
// tolerance with its default of 7
// the receiver cannot stall: feature is held for one cycle only
`default_nettype none
module point_triangle_feature_classify #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [COORD_WIDTH-1:0]   v0_x,
	input  logic signed [COORD_WIDTH-1:0]   v0_y,
	input  logic signed [COORD_WIDTH-1:0]   v0_z,
	input  logic signed [COORD_WIDTH-1:0]   v1_x,
	input  logic signed [COORD_WIDTH-1:0]   v1_y,
	input  logic signed [COORD_WIDTH-1:0]   v1_z,
	input  logic signed [COORD_WIDTH-1:0]   v2_x,
	input  logic signed [COORD_WIDTH-1:0]   v2_y,
	input  logic signed [COORD_WIDTH-1:0]   v2_z,
	input  logic signed [COORD_WIDTH-1:0]   query_x,
	input  logic signed [COORD_WIDTH-1:0]   query_y,
	input  logic signed [COORD_WIDTH-1:0]   query_z,
	output logic                            done,
	output ptfc_pkg::feature_t              feature,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ptfc_pkg::TOL_W-1:0]      cfg_data
);
	import ptfc_pkg::*;

	localparam int DW = COORD_WIDTH + 1;
	localparam int PW = 2 * DW;
	localparam int LW = PW + 2;

	logic [TOL_W-1:0] tolerance_q;
	logic signed [COORD_WIDTH-1:0] vtx [3][3];
	logic signed [COORD_WIDTH-1:0] qry [3];
	logic signed [DW-1:0] p_s1 [3][3];
	logic signed [DW-1:0] d_s1 [3][3];
	logic [TOL_W-1:0] tol_s1;
	logic signed [TSQ_W-1:0] tsq_s3;
	logic signed [TSQ_W-1:0] tsq_s4;
	logic signed [PW-1:0] psq [3][3];
	logic signed [LW-1:0] dist_s4 [3];
	logic vnear_s5, vnear_s6, vnear_s7, vnear_s8;
	logic [2:0] enear_s8;
	feature_t feature_s9;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			tolerance_q <= cfg_data;
		end
	end

	assign vtx[0][0] = v0_x;
	assign vtx[0][1] = v0_y;
	assign vtx[0][2] = v0_z;
	assign vtx[1][0] = v1_x;
	assign vtx[1][1] = v1_y;
	assign vtx[1][2] = v1_z;
	assign vtx[2][0] = v2_x;
	assign vtx[2][1] = v2_y;
	assign vtx[2][2] = v2_z;
	assign qry[0] = query_x;
	assign qry[1] = query_y;
	assign qry[2] = query_z;

	// query offsets from each vertex and edge directions
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				p_s1[i][k] <= DW'(qry[k]) - DW'(vtx[i][k]);
				d_s1[i][k] <= DW'(vtx[NEXT_IDX[i]][k]) - DW'(vtx[i][k]);
			end
		end
		tol_s1 <= tolerance_q;
	end

	ptfc_mul #(.A_W(TOL_W + 1), .B_W(TOL_W + 1)) u_tsq (
		.clk (clk),
		.a   ($signed({1'b0, tol_s1})),
		.b   ($signed({1'b0, tol_s1})),
		.p   (tsq_s3)
	);

	for (genvar i = 0; i < 3; i++) begin : g_v
		for (genvar k = 0; k < 3; k++) begin : g_k
			ptfc_mul #(.A_W(DW), .B_W(DW)) u_psq (
				.clk (clk),
				.a   (p_s1[i][k]),
				.b   (p_s1[i][k]),
				.p   (psq[i][k])
			);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dist_s4[i] <= LW'(psq[i][0]) + LW'(psq[i][1]) + LW'(psq[i][2]);
		end
		tsq_s4 <= tsq_s3;
		vnear_s5 <= (dist_s4[0] < LW'(tsq_s4)) || (dist_s4[1] < LW'(tsq_s4)) ||
			(dist_s4[2] < LW'(tsq_s4));
		vnear_s6 <= vnear_s5;
		vnear_s7 <= vnear_s6;
		vnear_s8 <= vnear_s7;
	end

	// edge i runs from vertex i to the next vertex
	for (genvar e = 0; e < 3; e++) begin : g_e
		ptfc_edge #(.DW(DW)) u_edge (
			.clk       (clk),
			.d_s1      (d_s1[e]),
			.p_s1      (p_s1[e]),
			.tol_sq_s3 (tsq_s3),
			.near_s8   (enear_s8[e])
		);
	end

	always_ff @(posedge clk) begin
		if (vnear_s8) begin
			feature_s9 <= FEAT_VERTEX;
		end else if (|enear_s8) begin
			feature_s9 <= FEAT_EDGE;
		end else begin
			feature_s9 <= FEAT_FACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	assign done = vld_s9;
	assign feature = feature_s9;

endmodule
`default_nettype wire
